@@ rtl/max_product_edge_relaxation_assert.svh @@
// Assertion macros used by the edge relaxation back end.
`ifndef MAX_PRODUCT_EDGE_RELAXATION_ASSERT_SVH
`define MAX_PRODUCT_EDGE_RELAXATION_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mpe_pkg.sv @@
// Types and constants of the max-product edge relaxation engine.
package mpe_pkg;

    localparam int NODE_BITS   = 10;
    localparam int LOAD_BITS   = 24;
    localparam int WEIGHT_BITS = 24;
    localparam int CNT_BITS    = 32;

    localparam int NODE_COUNT_DEF = 1024;
    localparam int VALUE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [2:0] OP_LOAD_CUR    = 3'd0;
    localparam logic [2:0] OP_LOAD_NEXT   = 3'd1;
    localparam logic [2:0] OP_CLEAR_VISIT = 3'd2;
    localparam logic [2:0] OP_RELAX       = 3'd3;
    localparam logic [2:0] OP_READ_PARENT = 3'd4;

    typedef enum logic [2:0] {
        K_NOP,
        K_LOAD_CUR,
        K_LOAD_NEXT,
        K_CLEAR,
        K_RELAX,
        K_READ
    } kind_t;

    typedef struct packed {
        kind_t                         kind;
        logic                          blk;
        logic [NODE_BITS-1:0]          src;
        logic [NODE_BITS-1:0]          dst;
        logic signed [WEIGHT_BITS-1:0] weight;
        logic signed [LOAD_BITS-1:0]   load_value;
    } cmd_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MUL,
        S_EVAL
    } state_t;

endpackage

@@ rtl/mpe_if.sv @@
// Command and result channel interfaces of the relaxation engine.
interface mpe_cmd_if;
    logic                                     valid;
    logic                                     ready;
    logic [2:0]                               op;
    logic [mpe_pkg::NODE_BITS-1:0]            src_node;
    logic [mpe_pkg::NODE_BITS-1:0]            dst_node;
    logic signed [mpe_pkg::WEIGHT_BITS-1:0]   weight;
    logic signed [mpe_pkg::LOAD_BITS-1:0]     load_value;
    logic                                     block_start;

    modport source (output valid, op, src_node, dst_node, weight, load_value, block_start,
                    input ready);
    modport sink   (input valid, op, src_node, dst_node, weight, load_value, block_start,
                    output ready);
endinterface

interface mpe_res_if;
    logic                               valid;
    logic                               ready;
    logic                               pushed;
    logic [mpe_pkg::NODE_BITS-1:0]      pushed_node;
    logic                               first_visit;
    logic                               goal_hit;
    logic [mpe_pkg::NODE_BITS-1:0]      parent_node;
    logic [mpe_pkg::CNT_BITS-1:0]       visited_count;
    logic [mpe_pkg::CNT_BITS-1:0]       edge_count;
    logic [mpe_pkg::CNT_BITS-1:0]       block_count;

    modport source (output valid, pushed, pushed_node, first_visit, goal_hit, parent_node,
                    visited_count, edge_count, block_count, input ready);
    modport sink   (input valid, pushed, pushed_node, first_visit, goal_hit, parent_node,
                    visited_count, edge_count, block_count, output ready);
endinterface

@@ rtl/mpe_front.sv @@
// Front end: accepts command words and classifies them for the back end.
module mpe_front #(
    parameter int NODE_COUNT = mpe_pkg::NODE_COUNT_DEF
) (
    mpe_cmd_if.sink        cmd,
    input  logic           clearing,
    input  logic           q_full,
    output logic           q_push,
    output mpe_pkg::cmd_t  q_data
);
    import mpe_pkg::*;

    logic dst_ok;
    logic src_ok;

    assign dst_ok = 17'(cmd.dst_node) < 17'(NODE_COUNT);
    assign src_ok = 17'(cmd.src_node) < 17'(NODE_COUNT);

    assign cmd.ready = !q_full && !clearing;
    assign q_push    = cmd.valid && cmd.ready;

    always_comb
    begin
        q_data.kind       = K_NOP;
        q_data.blk        = 1'b0;
        q_data.src        = cmd.src_node;
        q_data.dst        = cmd.dst_node;
        q_data.weight     = cmd.weight;
        q_data.load_value = cmd.load_value;
        case (cmd.op)
            OP_LOAD_CUR:    q_data.kind = dst_ok ? K_LOAD_CUR : K_NOP;
            OP_LOAD_NEXT:   q_data.kind = dst_ok ? K_LOAD_NEXT : K_NOP;
            OP_CLEAR_VISIT: q_data.kind = dst_ok ? K_CLEAR : K_NOP;
            OP_RELAX:
            begin
                // A block mark counts even when the edge itself is out of range.
                q_data.blk  = cmd.block_start;
                q_data.kind = (dst_ok && src_ok) ? K_RELAX : K_NOP;
            end
            OP_READ_PARENT: q_data.kind = dst_ok ? K_READ : K_NOP;
            default:        q_data.kind = K_NOP;
        endcase
    end

endmodule

@@ rtl/mpe_queue.sv @@
// Two-entry command queue between the front and back ends.
module mpe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mpe_pkg::cmd_t  push_data,
    input  logic           pop,
    output mpe_pkg::cmd_t  pop_data,
    output logic           full,
    output logic           empty
);
    import mpe_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/mpe_back.sv @@
// Back end: node tables, fixed-point relax datapath, totals and result register.
`include "max_product_edge_relaxation_assert.svh"

module mpe_back #(
    parameter int NODE_COUNT = mpe_pkg::NODE_COUNT_DEF,
    parameter int VALUE_BITS = mpe_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = mpe_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mpe_pkg::cmd_t                  q_data,
    input  logic                           q_empty,
    output logic                           q_pop,
    output logic                           clearing,
    input  logic [mpe_pkg::NODE_BITS-1:0]  goal_node,
    mpe_res_if.source                      res
);
    import mpe_pkg::*;

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PW = VALUE_BITS + WEIGHT_BITS;
    localparam logic signed [PW-1:0] VMAX = PW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] VMIN = PW'(-(64'sd1 <<< (VALUE_BITS - 1)));
    localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);

    function automatic logic signed [VALUE_BITS-1:0] sat_val(input logic signed [PW-1:0] x);
        if (x > VMAX)
            return VMAX[VALUE_BITS-1:0];
        if (x < VMIN)
            return VMIN[VALUE_BITS-1:0];
        return x[VALUE_BITS-1:0];
    endfunction

    function automatic logic [CNT_BITS-1:0] inc_sat(input logic [CNT_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Node tables.
    logic signed [VALUE_BITS-1:0] cur_mem  [NODE_COUNT];
    logic signed [VALUE_BITS-1:0] next_mem [NODE_COUNT];
    logic                         vis_mem  [NODE_COUNT];
    logic [NODE_BITS-1:0]         par_mem  [NODE_COUNT];

    logic signed [VALUE_BITS-1:0] cur_rd_reg;
    logic signed [VALUE_BITS-1:0] next_rd_reg;
    logic                         vis_rd_reg;
    logic [NODE_BITS-1:0]         par_rd_reg;
    logic signed [PW-1:0]         prod_reg;

    state_t               state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [CNT_BITS-1:0]  visits_reg, visits_next;
    logic [CNT_BITS-1:0]  edges_reg, edges_next;
    logic [CNT_BITS-1:0]  blocks_reg, blocks_next;
    logic                 goal_reg, goal_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_pushed_reg, out_pushed_next;
    logic [NODE_BITS-1:0] out_pnode_reg, out_pnode_next;
    logic                 out_first_reg, out_first_next;
    logic [NODE_BITS-1:0] out_parent_reg, out_parent_next;

    logic [AW-1:0]                src_a;
    logic [AW-1:0]                dst_a;
    logic signed [PW-1:0]         shifted;
    logic signed [VALUE_BITS-1:0] relax_val;
    logic signed [VALUE_BITS-1:0] load_val;
    logic                         active;
    logic                         out_free;
    logic                         commit;
    logic                         cur_we;
    logic                         next_we;
    logic signed [VALUE_BITS-1:0] next_wd;
    logic                         vis_we;
    logic                         vis_wd;
    logic [AW-1:0]                vis_wa;
    logic                         par_we;

    assign src_a     = AW'(cmd_reg.src);
    assign dst_a     = AW'(cmd_reg.dst);
    assign shifted   = prod_reg >>> FRAC_BITS;
    assign relax_val = sat_val(shifted);
    assign load_val  = sat_val(PW'(cmd_reg.load_value));
    assign active    = !cur_rd_reg[VALUE_BITS-1] && (cur_rd_reg != '0);
    assign out_free  = !out_valid_reg || res.ready;
    assign commit    = (state_reg == S_EVAL) && out_free;
    assign clearing  = state_reg == S_CLEAR;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        q_pop           = 1'b0;
        visits_next     = visits_reg;
        edges_next      = edges_reg;
        blocks_next     = blocks_reg;
        goal_next       = goal_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_pushed_next = out_pushed_reg;
        out_pnode_next  = out_pnode_reg;
        out_first_next  = out_first_reg;
        out_parent_next = out_parent_reg;
        cur_we          = 1'b0;
        next_we         = 1'b0;
        next_wd         = load_val;
        vis_we          = 1'b0;
        vis_wd          = 1'b0;
        vis_wa          = dst_a;
        par_we          = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep the visited marks to zero, one entry per cycle.
                vis_we        = 1'b1;
                vis_wa        = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_MUL;
            S_MUL:   state_next = S_EVAL;
            S_EVAL:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_pushed_next = 1'b0;
                    out_pnode_next  = '0;
                    out_first_next  = 1'b0;
                    out_parent_next = '0;
                    if (cmd_reg.blk)
                    begin
                        blocks_next = inc_sat(blocks_reg);
                    end
                    case (cmd_reg.kind)
                        K_LOAD_CUR:  cur_we = 1'b1;
                        K_LOAD_NEXT: next_we = 1'b1;
                        K_CLEAR:     vis_we = 1'b1;
                        K_READ:      out_parent_next = par_rd_reg;
                        K_RELAX:
                        begin
                            if (active)
                            begin
                                edges_next = inc_sat(edges_reg);
                                if (cmd_reg.dst == goal_node)
                                begin
                                    goal_next = 1'b1;
                                end
                                if (relax_val > next_rd_reg)
                                begin
                                    next_we         = 1'b1;
                                    next_wd         = relax_val;
                                    out_pushed_next = 1'b1;
                                    out_pnode_next  = cmd_reg.dst;
                                end
                                if (!vis_rd_reg)
                                begin
                                    vis_we         = 1'b1;
                                    vis_wd         = 1'b1;
                                    par_we         = 1'b1;
                                    visits_next    = inc_sat(visits_reg);
                                    out_first_next = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            visits_reg    <= '0;
            edges_reg     <= '0;
            blocks_reg    <= '0;
            goal_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            visits_reg    <= visits_next;
            edges_reg     <= edges_next;
            blocks_reg    <= blocks_next;
            goal_reg      <= goal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pushed_reg <= out_pushed_next;
        out_pnode_reg  <= out_pnode_next;
        out_first_reg  <= out_first_next;
        out_parent_reg <= out_parent_next;
        if (q_pop)
        begin
            cmd_reg <= q_data;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= cur_rd_reg * cmd_reg.weight;
        end
    end

    // Table reads, registered.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            cur_rd_reg  <= cur_mem[src_a];
            next_rd_reg <= next_mem[dst_a];
            vis_rd_reg  <= vis_mem[dst_a];
            par_rd_reg  <= par_mem[dst_a];
        end
    end

    // Table writes.
    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[dst_a] <= load_val;
        end
        if (next_we)
        begin
            next_mem[dst_a] <= next_wd;
        end
        if (vis_we)
        begin
            vis_mem[vis_wa] <= vis_wd;
        end
        if (par_we)
        begin
            par_mem[dst_a] <= cmd_reg.src;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.pushed        = out_pushed_reg;
    assign res.pushed_node   = out_pnode_reg;
    assign res.first_visit   = out_first_reg;
    assign res.goal_hit      = goal_reg;
    assign res.parent_node   = out_parent_reg;
    assign res.visited_count = visits_reg;
    assign res.edge_count    = edges_reg;
    assign res.block_count   = blocks_reg;

    `MPE_ASSERT_NOW(a_clear_no_cmd, state_reg == S_CLEAR, q_empty, "command queued during clear")
    `MPE_ASSERT_NEXT(a_goal_sticky, goal_reg, goal_reg, "goal flag dropped")
    `MPE_ASSERT_NEXT(a_commit_shows, commit, out_valid_reg, "committed word not presented")
    `MPE_ASSERT_NOW(a_push_node, out_valid_reg && !out_pushed_reg, out_pnode_reg == '0,
        "pushed node set without a push")

endmodule

@@ rtl/max_product_edge_relaxation.sv @@
// Top level of the max-product edge relaxation engine.
// After reset the engine sweeps its visited marks to zero and takes no command words until
// that is done; the goal register may be written meanwhile. Each command word then passes
// through the back-end sequencer in order (dequeue, table read, multiply, evaluate and
// write back), and the back end finishes one word before it takes the next. A two-entry
// queue lets the front end take words while the back end works. A result that waits to be
// taken holds the back end in its evaluate step, so the queue then fills and the input stalls.
module max_product_edge_relaxation #(
    parameter int NODE_COUNT = mpe_pkg::NODE_COUNT_DEF,
    parameter int VALUE_BITS = mpe_pkg::VALUE_BITS_DEF,
    parameter int FRAC_BITS  = mpe_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mpe_pkg::NODE_BITS-1:0] cfg_wdata,
    mpe_cmd_if.sink                       cmd,
    mpe_res_if.source                     res
);
    import mpe_pkg::*;

    logic [NODE_BITS-1:0] goal_node_reg;
    cmd_t                 push_data;
    cmd_t                 pop_data;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    logic                 clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_node_reg <= '0;
        end
        else if (cfg_we)
        begin
            goal_node_reg <= cfg_wdata;
        end
    end

    mpe_front #(
        .NODE_COUNT (NODE_COUNT)
    ) u_front (
        .cmd      (cmd),
        .clearing (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    mpe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    mpe_back #(
        .NODE_COUNT (NODE_COUNT),
        .VALUE_BITS (VALUE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (pop_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .goal_node (goal_node_reg),
        .res       (res)
    );

endmodule
